[rtl/kwms_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwms_pkg
// Shared widths, codes and controller/datapath types of the k-way run merge
// selector.
// ----------------------------------------------------------------------------
package kwms_pkg;

	localparam int LANES_DEF    = 16;
	localparam int KEY_BITS_DEF = 64;

	localparam int CMD_W  = 2;
	localparam int LANE_W = 4;
	localparam int KEY_W  = 64;
	localparam int TAG_W  = 32;
	localparam int LEN_W  = 25;
	localparam int DEST_W = 4;

	// records released per input word at most
	localparam int MAX_OUT    = 16;
	localparam int EMIT_CNT_W = $clog2(MAX_OUT + 1);

	typedef enum logic [CMD_W-1:0] {
		CMD_RECORD  = 2'd0,
		CMD_END     = 2'd1,
		CMD_RESTART = 2'd2
	} kwms_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE
	} kwms_state_t;

	typedef struct packed {
		logic accept;     // input word taken this cycle
		logic scan_clr;   // restart the head scan
		logic scan_step;  // visit one lane
		logic emit;       // load the winner into the output register
		logic close;      // close the run after an end mark
	} kwms_ctrl_t;

	typedef struct packed {
		logic proceed;    // input word is a record or end mark for a real lane
		logic scan_last;  // scan is at the last lane
		logic out_free;   // output register can take a word
		logic can_close;  // end mark left every lane done with nothing held
		logic can_emit;   // every lane held or done, and a head exists
	} kwms_status_t;

endpackage

[rtl/kwms_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwms interfaces
// Valid/ready channels of the merge selector: input words, merged records
// and the run length write port.
// ----------------------------------------------------------------------------
interface kwms_in_if;
	import kwms_pkg::*;

	logic             valid;
	logic             ready;
	logic [CMD_W-1:0]  cmd;
	logic [LANE_W-1:0] lane;
	logic [KEY_W-1:0]  record_key;
	logic [TAG_W-1:0]  record_tag;

	modport source (output valid, cmd, lane, record_key, record_tag, input ready);
	modport sink   (input valid, cmd, lane, record_key, record_tag, output ready);
endinterface

interface kwms_out_if;
	import kwms_pkg::*;

	logic              valid;
	logic              ready;
	logic [KEY_W-1:0]  out_key;
	logic [TAG_W-1:0]  out_tag;
	logic [LANE_W-1:0] source_lane;
	logic [DEST_W-1:0] dest_file;
	logic              last_of_run;

	modport source (output valid, out_key, out_tag, source_lane, dest_file, last_of_run,
		input ready);
	modport sink   (input valid, out_key, out_tag, source_lane, dest_file, last_of_run,
		output ready);
endinterface

interface kwms_cfg_if;
	import kwms_pkg::*;

	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] run_length;

	modport source (output valid, run_length, input ready);
	modport sink   (input valid, run_length, output ready);
endinterface

[rtl/kwms_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwms_ctrl
// Sequencer: takes an input word; for a record or end mark on a real lane it
// runs a lane scan, then emits the winner and rescans, closes the run or idles.
// ----------------------------------------------------------------------------
module kwms_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  src_valid,
	output logic                  src_ready,
	input  kwms_pkg::kwms_status_t st,
	output kwms_pkg::kwms_ctrl_t   cmd
);
	import kwms_pkg::*;

	kwms_state_t           state_q, state_d;
	logic [EMIT_CNT_W-1:0] emit_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_cnt_q <= '0;
		end else if (cmd.accept) begin
			emit_cnt_q <= '0;
		end else if (cmd.emit) begin
			emit_cnt_q <= emit_cnt_q + EMIT_CNT_W'(1);
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		src_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				src_ready = 1'b1;
				if (src_valid) begin
					cmd.accept = 1'b1;
					if (st.proceed) begin
						cmd.scan_clr = 1'b1;
						state_d      = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (st.scan_last) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (st.can_close) begin
					cmd.close = 1'b1;
					state_d   = ST_IDLE;
				end else if (st.can_emit && emit_cnt_q < EMIT_CNT_W'(MAX_OUT)) begin
					// hold here while the output register is occupied
					if (st.out_free) begin
						cmd.emit     = 1'b1;
						cmd.scan_clr = 1'b1;
						state_d      = ST_SCAN;
					end
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_emit_cap: assert property (@(posedge clk) disable iff (!arst_n)
		emit_cnt_q <= EMIT_CNT_W'(MAX_OUT))
		else $error("emit count above per-word limit");

	a_emit_rescan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> state_q == ST_SCAN)
		else $error("no rescan after emit");

	a_take_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(src_valid && src_ready && st.proceed) |=> (state_q == ST_SCAN && emit_cnt_q == '0))
		else $error("accepted word did not start a scan");

endmodule

[rtl/kwms_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwms_datapath
// Head store, per-lane counters, run index, the one-lane-per-cycle minimum
// scan and the output register.
// ----------------------------------------------------------------------------
module kwms_datapath #(
	parameter int LANES    = kwms_pkg::LANES_DEF,
	parameter int KEY_BITS = kwms_pkg::KEY_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [kwms_pkg::CMD_W-1:0]  in_cmd,
	input  logic [kwms_pkg::LANE_W-1:0] in_lane,
	input  logic [kwms_pkg::KEY_W-1:0]  in_key,
	input  logic [kwms_pkg::TAG_W-1:0]  in_tag,
	input  logic                        cfg_valid,
	input  logic [kwms_pkg::LEN_W-1:0]  cfg_len,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [kwms_pkg::KEY_W-1:0]  out_key,
	output logic [kwms_pkg::TAG_W-1:0]  out_tag,
	output logic [kwms_pkg::LANE_W-1:0] out_lane,
	output logic [kwms_pkg::DEST_W-1:0] out_dest,
	output logic                        out_last,
	input  kwms_pkg::kwms_ctrl_t         cmd,
	output kwms_pkg::kwms_status_t       st
);
	import kwms_pkg::*;

	localparam int LW      = $clog2(LANES);
	localparam int LANE_EXT = (LW > LANE_W) ? LW : LANE_W;

	// lane state
	logic [KEY_BITS-1:0] head_key_q [LANES];
	logic [TAG_W-1:0]    head_tag_q [LANES];
	logic [LANES-1:0]    head_valid_q;
	logic [LANES-1:0]    lane_ended_q;
	logic [LEN_W-1:0]    taken_q [LANES];
	logic [LW-1:0]       run_index_q;
	logic [LEN_W-1:0]    run_length_q;
	logic                is_end_q;

	// scan accumulators
	logic [LW-1:0]       scan_idx_q;
	logic [LW-1:0]       best_idx_q;
	logic [KEY_BITS-1:0] best_key_q;
	logic [TAG_W-1:0]    best_tag_q;
	logic                any_q, multi_q, ready_q, all_done_q, any_taken_q;

	// output register
	logic                out_valid_q;
	logic [KEY_W-1:0]    out_key_q;
	logic [TAG_W-1:0]    out_tag_q;
	logic [LANE_W-1:0]   out_lane_q;
	logic [DEST_W-1:0]   out_dest_q;
	logic                out_last_q;

	logic [LANE_EXT-1:0] lane_ext, best_ext, run_ext;
	logic [LW-1:0]       lane_idx;
	logic                lane_ok, restart, rec_take, end_take;
	logic [LEN_W-1:0]    eff_len;
	logic                sc_valid, sc_done, sc_better, last_emit, do_close;
	logic [LW-1:0]       run_next;

	assign lane_ext = LANE_EXT'(in_lane);
	assign lane_idx = lane_ext[LW-1:0];
	assign lane_ok  = 32'(in_lane) < 32'(LANES);
	assign eff_len  = (run_length_q == '0) ? LEN_W'(1) : run_length_q;

	assign restart  = cmd.accept && in_cmd == CMD_RESTART;
	assign rec_take = cmd.accept && lane_ok && in_cmd == CMD_RECORD
		&& !lane_ended_q[lane_idx] && !head_valid_q[lane_idx]
		&& taken_q[lane_idx] < eff_len;
	assign end_take = cmd.accept && lane_ok && in_cmd == CMD_END;

	assign sc_valid  = head_valid_q[scan_idx_q];
	assign sc_done   = lane_ended_q[scan_idx_q] || taken_q[scan_idx_q] >= eff_len;
	assign sc_better = !any_q || head_key_q[scan_idx_q] < best_key_q;

	// winner closes the run when no other head is held and every lane is done
	assign last_emit = all_done_q && !multi_q;
	assign do_close  = cmd.close || (cmd.emit && last_emit);
	assign run_next  = (run_index_q == LW'(LANES - 1)) ? '0 : run_index_q + LW'(1);

	assign st.proceed   = lane_ok && (in_cmd == CMD_RECORD || in_cmd == CMD_END);
	assign st.scan_last = scan_idx_q == LW'(LANES - 1);
	assign st.out_free  = !out_valid_q || out_ready;
	assign st.can_close = is_end_q && any_taken_q && all_done_q && !any_q;
	assign st.can_emit  = ready_q && any_q;

	always_ff @(posedge clk) begin
		if (rec_take) begin
			head_key_q[lane_idx] <= in_key[KEY_BITS-1:0];
			head_tag_q[lane_idx] <= in_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= '0;
			lane_ended_q <= '0;
			run_index_q  <= '0;
			is_end_q     <= 1'b0;
			for (int i = 0; i < LANES; i++) begin
				taken_q[i] <= '0;
			end
		end else if (restart) begin
			head_valid_q <= '0;
			lane_ended_q <= '0;
			run_index_q  <= '0;
			is_end_q     <= 1'b0;
			for (int i = 0; i < LANES; i++) begin
				taken_q[i] <= '0;
			end
		end else begin
			if (cmd.accept) begin
				is_end_q <= end_take;
			end
			if (rec_take) begin
				head_valid_q[lane_idx] <= 1'b1;
				taken_q[lane_idx]      <= taken_q[lane_idx] + LEN_W'(1);
			end
			if (end_take) begin
				lane_ended_q[lane_idx] <= 1'b1;
			end
			if (cmd.emit) begin
				head_valid_q[best_idx_q] <= 1'b0;
				is_end_q                 <= 1'b0;
			end
			if (do_close) begin
				run_index_q <= run_next;
				for (int i = 0; i < LANES; i++) begin
					taken_q[i] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_length_q <= LEN_W'(1);
		end else if (cfg_valid) begin
			run_length_q <= cfg_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q  <= '0;
			any_q       <= 1'b0;
			multi_q     <= 1'b0;
			ready_q     <= 1'b0;
			all_done_q  <= 1'b0;
			any_taken_q <= 1'b0;
		end else if (cmd.scan_clr) begin
			scan_idx_q  <= '0;
			any_q       <= 1'b0;
			multi_q     <= 1'b0;
			ready_q     <= 1'b1;
			all_done_q  <= 1'b1;
			any_taken_q <= 1'b0;
		end else if (cmd.scan_step) begin
			scan_idx_q  <= scan_idx_q + LW'(1);
			ready_q     <= ready_q && (sc_valid || sc_done);
			all_done_q  <= all_done_q && sc_done;
			any_taken_q <= any_taken_q || taken_q[scan_idx_q] != '0;
			if (sc_valid) begin
				any_q   <= 1'b1;
				multi_q <= multi_q || any_q;
			end
		end
	end

	// strict compare keeps the lowest lane on equal keys
	always_ff @(posedge clk) begin
		if (cmd.scan_step && sc_valid && sc_better) begin
			best_idx_q <= scan_idx_q;
			best_key_q <= head_key_q[scan_idx_q];
			best_tag_q <= head_tag_q[scan_idx_q];
		end
	end

	assign best_ext = LANE_EXT'(best_idx_q);
	assign run_ext  = LANE_EXT'(run_index_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_key_q  <= KEY_W'(best_key_q);
			out_tag_q  <= best_tag_q;
			out_lane_q <= best_ext[LANE_W-1:0];
			out_dest_q <= run_ext[DEST_W-1:0];
			out_last_q <= last_emit;
		end
	end

	assign out_valid = out_valid_q;
	assign out_key   = out_key_q;
	assign out_tag   = out_tag_q;
	assign out_lane  = out_lane_q;
	assign out_dest  = out_dest_q;
	assign out_last  = out_last_q;

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (st.out_free && any_q && ready_q))
		else $error("emit without room or without a winner");

	a_emit_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q)
		else $error("emitted word not presented");

	a_run_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(run_index_q) |-> $past(do_close || restart))
		else $error("run index moved without close or restart");

endmodule

[rtl/kway_run_merge_selector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kway_run_merge_selector
// K-way run merge: holds one head per lane and emits the smallest once every
// lane holds a head or is done.
// ----------------------------------------------------------------------------
// One input word at a time. A word is accepted in the idle state, then every
// scan visits the lanes one per cycle and ends in a decision state; each
// record released starts a new scan, and the decision waits while the output
// is stalled. A restart, an unused command or an out-of-range lane is taken
// without a scan. At most 16 records leave per word; more waiting ones follow
// the next record or end mark. The output register lets the next word in
// while a record waits. run_length is written over cfg; the user must write
// it only while the block is idle, which the block itself does not enforce.
module kway_run_merge_selector #(
	parameter int LANES    = kwms_pkg::LANES_DEF,
	parameter int KEY_BITS = kwms_pkg::KEY_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	kwms_in_if.sink      src,
	kwms_out_if.source   dst,
	kwms_cfg_if.sink     cfg
);
	import kwms_pkg::*;

	kwms_ctrl_t   cmd;
	kwms_status_t st;

	assign cfg.ready = 1'b1;

	kwms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src.valid),
		.src_ready (src.ready),
		.st        (st),
		.cmd       (cmd)
	);

	kwms_datapath #(
		.LANES    (LANES),
		.KEY_BITS (KEY_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_cmd    (src.cmd),
		.in_lane   (src.lane),
		.in_key    (src.record_key),
		.in_tag    (src.record_tag),
		.cfg_valid (cfg.valid),
		.cfg_len   (cfg.run_length),
		.out_valid (dst.valid),
		.out_ready (dst.ready),
		.out_key   (dst.out_key),
		.out_tag   (dst.out_tag),
		.out_lane  (dst.source_lane),
		.out_dest  (dst.dest_file),
		.out_last  (dst.last_of_run),
		.cmd       (cmd),
		.st        (st)
	);

endmodule

[tb/tb_kway_run_merge_selector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kway_run_merge_selector
// Self-checking bench for the k-way run merge selector. A cycle-free model of
// the head store, the done rules and the run counter predicts every merged
// record. Directed words cover fan-out, ties, drops and end-mark closes.
// Random passes then stream mostly well-formed refills at several run lengths,
// with idle bursts on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_kway_run_merge_selector;
	import kwms_pkg::*;

	localparam int LANES         = LANES_DEF;
	localparam int SETTLE_CYCLES = 1 + (MAX_OUT + 1) * (LANES + 1) + 20;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int PRINT_LIMIT   = 40;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [TAG_W-1:0]  tag;
		logic [LANE_W-1:0] lane;
		logic [DEST_W-1:0] dest;
		logic              last;
	} merged_rec_t;

	logic clk = 1'b0;
	logic arst_n;

	kwms_in_if  in_ch();
	kwms_out_if out_ch();
	kwms_cfg_if cfg_ch();

	kway_run_merge_selector dut (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (in_ch),
		.dst    (out_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// merge model state
	logic [KEY_W-1:0]  head_key_m [LANES];
	logic [TAG_W-1:0]  head_tag_m [LANES];
	bit                held_m     [LANES];
	bit                ended_m    [LANES];
	int unsigned       taken_m    [LANES];
	logic [DEST_W-1:0] run_idx_m;
	logic [LEN_W-1:0]  run_len_m;

	merged_rec_t pending_merges[$];
	int          errors;
	int          hold_off_cycles;
	bit          calm;

	task automatic flag_mismatch(input string what);
		errors++;
		if (errors <= PRINT_LIMIT)
			$display("MISMATCH at %0t ns: %s", $time, what);
	endtask

	function automatic int unsigned span();
		return (run_len_m == 0) ? 1 : int'(run_len_m);
	endfunction

	function automatic bit lane_done(input int i);
		return ended_m[i] || taken_m[i] >= span();
	endfunction

	function automatic bit run_drained();
		for (int i = 0; i < LANES; i++)
			if (held_m[i] || !lane_done(i))
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic void close_run();
		foreach (taken_m[i])
			taken_m[i] = 0;
		run_idx_m = DEST_W'((int'(run_idx_m) + 1) % LANES);
	endfunction

	function automatic void clear_pass();
		foreach (held_m[i]) begin
			head_key_m[i] = '0;
			head_tag_m[i] = '0;
			held_m[i]     = 1'b0;
			ended_m[i]    = 1'b0;
			taken_m[i]    = 0;
		end
		run_idx_m = '0;
	endfunction

	// apply one accepted word and queue every record it releases
	function automatic void merge_predict(input logic [CMD_W-1:0] c, input logic [LANE_W-1:0] ln,
		input logic [KEY_W-1:0] k, input logic [TAG_W-1:0] t);
		merged_rec_t rec;
		bit          ready;
		bit          any;
		bit          fin;
		int          best;
		int          n;
		if (c == CMD_RESTART) begin
			clear_pass();
			return;
		end
		if (c == CMD_UNUSED || int'(ln) >= LANES)
			return;
		if (c == CMD_RECORD) begin
			if (!ended_m[ln] && !held_m[ln] && taken_m[ln] < span()) begin
				head_key_m[ln] = k;
				head_tag_m[ln] = t;
				held_m[ln]     = 1'b1;
				taken_m[ln]++;
			end
		end else begin
			any = 1'b0;
			ended_m[ln] = 1'b1;
			foreach (taken_m[i])
				if (taken_m[i] != 0)
					any = 1'b1;
			// an end mark may close the run with no record out
			if (any && run_drained())
				close_run();
		end
		n = 0;
		while (n < MAX_OUT) begin
			ready = 1'b1;
			any   = 1'b0;
			best  = 0;
			for (int i = 0; i < LANES; i++) begin
				if (held_m[i]) begin
					if (!any || head_key_m[i] < head_key_m[best])
						best = i;
					any = 1'b1;
				end else if (!lane_done(i)) begin
					ready = 1'b0;
				end
			end
			if (!ready || !any)
				break;
			held_m[best] = 1'b0;
			fin = run_drained();
			rec.key  = head_key_m[best];
			rec.tag  = head_tag_m[best];
			rec.lane = LANE_W'(best);
			rec.dest = run_idx_m;
			rec.last = fin;
			pending_merges.push_back(rec);
			n++;
			if (fin)
				close_run();
		end
	endfunction

	function automatic logic [KEY_W-1:0] rand_key();
		int mode;
		mode = $urandom_range(0, 7);
		if (mode < 2)
			return KEY_W'($urandom_range(0, 3));
		if (mode == 2)
			return $urandom_range(0, 1) ? '1 : '0;
		return {$urandom, $urandom};
	endfunction

	// one input word, with an optional idle burst in front
	task automatic send_word(input logic [CMD_W-1:0] c, input logic [LANE_W-1:0] ln,
		input logic [KEY_W-1:0] k, input logic [TAG_W-1:0] t);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			@(negedge clk);
			in_ch.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid      = 1'b1;
		in_ch.cmd        = c;
		in_ch.lane       = ln;
		in_ch.record_key = k;
		in_ch.record_tag = t;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		merge_predict(c, ln, k, t);
	endtask

	task automatic wait_idle();
		int waited;
		waited = 0;
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (pending_merges.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_merges.size() != 0) begin
			flag_mismatch($sformatf("%0d merged records never arrived", pending_merges.size()));
			pending_merges.delete();
		end
		// a word with no record out may still be scanning
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_run_length(input logic [LEN_W-1:0] v);
		wait_idle();
		@(negedge clk);
		cfg_ch.valid      = 1'b1;
		cfg_ch.run_length = v;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		run_len_m = v;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// mostly refills of lanes that want a record, plus noise
	task automatic send_merge_traffic(input int count);
		int pick;
		int open_lanes[$];
		logic [LANE_W-1:0] ln;
		for (int n = 0; n < count; n++) begin
			open_lanes.delete();
			for (int i = 0; i < LANES; i++)
				if (!held_m[i] && !lane_done(i))
					open_lanes.push_back(i);
			pick = $urandom_range(0, 99);
			ln   = LANE_W'($urandom_range(0, LANES - 1));
			if (open_lanes.size() == 0 || pick < 2)
				send_word(CMD_RESTART, ln, rand_key(), $urandom);
			else if (pick < 80)
				send_word(CMD_RECORD, LANE_W'(open_lanes[$urandom_range(0, open_lanes.size() - 1)]),
					rand_key(), $urandom);
			else if (pick < 88)
				send_word(CMD_END, ln, rand_key(), $urandom);
			else if (pick < 96)
				send_word(CMD_RECORD, ln, rand_key(), $urandom);
			else
				send_word(CMD_UNUSED, ln, rand_key(), $urandom);
		end
	endtask

	// run length 0 acts as 1: filling all lanes releases the full 16-record fan-out
	task automatic test_fan_out_and_ties();
		program_run_length('0);
		send_word(CMD_UNUSED, 4'd7, '1, '1);
		send_word(CMD_RECORD, 4'd0, '1, '1);
		send_word(CMD_RECORD, 4'd1, '0, '0);
		send_word(CMD_RECORD, 4'd1, KEY_W'(5), 32'h0000_0005);
		send_word(CMD_RECORD, 4'd2, '0, 32'h8000_0000);
		for (int i = 3; i < LANES; i++)
			send_word(CMD_RECORD, LANE_W'(i), rand_key(), $urandom);
	endtask

	// end mark on a held lane, end-mark run close, then every lane ended
	task automatic test_end_marks();
		program_run_length(LEN_W'(3));
		send_word(CMD_RESTART, 4'd0, '0, '0);
		send_word(CMD_RECORD, 4'd5, KEY_W'(100), 32'h0000_0100);
		send_word(CMD_RECORD, 4'd9, KEY_W'(200), 32'h0000_0200);
		send_word(CMD_END, 4'd5, '0, '0);
		for (int i = 0; i < LANES; i++)
			if (i != 5 && i != 9)
				send_word(CMD_END, LANE_W'(i), '0, '0);
		send_word(CMD_END, 4'd9, '0, '0);
		send_word(CMD_RECORD, 4'd9, KEY_W'(7), 32'h0000_0007);
		send_word(CMD_UNUSED, 4'd15, '1, '1);
	endtask

	task automatic test_output_backpressure();
		program_run_length(LEN_W'(2));
		send_word(CMD_RESTART, 4'd0, '0, '0);
		hold_off_cycles = 1000;
		send_merge_traffic(40);
	endtask

	task automatic test_random_merge(input logic [LEN_W-1:0] len, input int count);
		program_run_length(len);
		send_word(CMD_RESTART, LANE_W'($urandom_range(0, LANES - 1)), '0, '0);
		send_merge_traffic(count);
	endtask

	// output ready: random stall bursts, or a long hold-off when asked
	initial begin
		int stall;
		stall = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				out_ch.ready = 1'b0;
				hold_off_cycles--;
			end else if (stall > 0) begin
				out_ch.ready = 1'b0;
				stall--;
			end else begin
				out_ch.ready = 1'b1;
				if (!calm && $urandom_range(0, 9) == 0)
					stall = $urandom_range(1, 18);
			end
		end
	end

	always @(posedge clk) begin
		merged_rec_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_merges.size() == 0) begin
				flag_mismatch($sformatf("record key %h from lane %0d with none pending",
					out_ch.out_key, out_ch.source_lane));
			end else begin
				want = pending_merges.pop_front();
				if (out_ch.out_key !== want.key)
					flag_mismatch($sformatf("out_key %h, want %h", out_ch.out_key, want.key));
				if (out_ch.out_tag !== want.tag)
					flag_mismatch($sformatf("out_tag %h, want %h", out_ch.out_tag, want.tag));
				if (out_ch.source_lane !== want.lane)
					flag_mismatch($sformatf("source_lane %0d, want %0d",
						out_ch.source_lane, want.lane));
				if (out_ch.dest_file !== want.dest)
					flag_mismatch($sformatf("dest_file %0d, want %0d", out_ch.dest_file, want.dest));
				if (out_ch.last_of_run !== want.last)
					flag_mismatch($sformatf("last_of_run %b, want %b",
						out_ch.last_of_run, want.last));
			end
		end
	end

	initial begin
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		errors           = 0;
		hold_off_cycles  = 0;
		calm             = 1'b0;
		arst_n           = 1'b0;
		in_ch.valid      = 1'b0;
		in_ch.cmd        = CMD_RECORD;
		in_ch.lane       = '0;
		in_ch.record_key = '0;
		in_ch.record_tag = '0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.run_length = '0;
		clear_pass();
		run_len_m = LEN_W'(1);
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_fan_out_and_ties();
		test_end_marks();
		test_output_backpressure();
		test_random_merge(LEN_W'(1), 37);
		test_random_merge(LEN_W'(3), 37);
		test_random_merge(LEN_W'(16777216), 37);
		test_random_merge('1, 37);
		calm = 1'b1;
		test_random_merge(LEN_W'(5), 37);
		wait_idle();

		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
